FILE: rtl/core/spbb_pkg.sv
// shared constants, register indexes, types and helpers for the sprite part bounding box block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package spbb_pkg;

  localparam int MAX_DIM      = 256;
  localparam int PALETTE_SIZE = 8;
  localparam int PART_COUNT   = 7;

  localparam int CODE_W  = 8;
  localparam int LABEL_W = 3;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int SIZE_W  = DIM_W + 1;
  localparam int IDX_W   = (PART_COUNT > 1) ? $clog2(PART_COUNT) : 1;

  // register widths as the register map defines them
  localparam int PAL_CHARS_W  = 64;
  localparam int PAL_PARTS_W  = 24;
  localparam int PAL_COUNT_W  = 4;
  localparam int SIZE_REG_W   = 9;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_ADDR_W   = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_PAL_CHARS  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PAL_PARTS  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PAL_COUNT  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPR_WIDTH  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SPR_HEIGHT = 3'd4;

  localparam int FIELDS_W = 2 * DIM_W + 2 * SIZE_W;
  localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
  localparam int TUSER_W  = LABEL_W + 1;

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_EMIT = 2'b10
  } spbb_state_t;

  typedef struct packed {
    logic             accept;
    logic             load;
    logic             clear_seen;
    logic [IDX_W-1:0] idx;
  } spbb_cmd_t;

  typedef struct packed {
    logic sprite_end;
  } spbb_status_t;

  // zero acts as one, anything past the largest sprite acts as the largest
  function automatic logic [SIZE_W-1:0] eff_dim(input logic [SIZE_REG_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = SIZE_W'(MAX_DIM);
    end else begin
      r = SIZE_W'(v);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/spbb_ctrl.sv
// controller for the sprite part bounding box block: pixel/emit sequencing and result handshake
// depends on spbb_pkg
`timescale 1ns / 1ps

module spbb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  spbb_pkg::spbb_status_t status,
  output spbb_pkg::spbb_cmd_t  cmd
);
  import spbb_pkg::*;

  spbb_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept, load, last_idx;

  assign in_tready = (state_r == ST_RUN);
  assign accept    = in_tvalid && in_tready;
  // result register is free or being drained this cycle
  assign load      = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  assign last_idx  = (idx_r == IDX_W'(PART_COUNT - 1));

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end
    case (state_r)
      ST_RUN: begin
        if (accept && status.sprite_end) begin
          state_nxt = ST_EMIT;
          idx_nxt   = '0;
        end
      end
      ST_EMIT: begin
        if (load) begin
          if (last_idx) begin
            state_nxt = ST_RUN;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
        idx_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid     = out_valid_r;
  assign cmd.accept     = accept;
  assign cmd.load       = load;
  assign cmd.clear_seen = load && last_idx;
  assign cmd.idx        = idx_r;

endmodule

FILE: rtl/core/spbb_datapath.sv
// datapath for the sprite part bounding box block: config registers, palette lookup,
// raster counters, per-label box lanes and the result register; depends on spbb_pkg
`timescale 1ns / 1ps

module spbb_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [spbb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [spbb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [spbb_pkg::CODE_W-1:0]     pixel_code,
  input  spbb_pkg::spbb_cmd_t             cmd,
  output spbb_pkg::spbb_status_t          status,
  output logic [spbb_pkg::LABEL_W-1:0]    part_label,
  output logic                            found,
  output logic [spbb_pkg::DIM_W-1:0]      box_left,
  output logic [spbb_pkg::DIM_W-1:0]      box_top,
  output logic [spbb_pkg::SIZE_W-1:0]     box_width,
  output logic [spbb_pkg::SIZE_W-1:0]     box_height,
  output logic                            last_of_run
);
  import spbb_pkg::*;

  logic [PAL_CHARS_W-1:0] pal_chars_r;
  logic [PAL_PARTS_W-1:0] pal_parts_r;
  logic [PAL_COUNT_W-1:0] pal_count_r;
  logic [SIZE_REG_W-1:0]  spr_width_r;
  logic [SIZE_REG_W-1:0]  spr_height_r;

  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;

  logic [PART_COUNT-1:0] seen_r, seen_nxt;
  logic [DIM_W-1:0]      min_col_r [PART_COUNT];
  logic [DIM_W-1:0]      max_col_r [PART_COUNT];
  logic [DIM_W-1:0]      min_row_r [PART_COUNT];
  logic [DIM_W-1:0]      max_row_r [PART_COUNT];
  logic [DIM_W-1:0]      min_col_nxt [PART_COUNT];
  logic [DIM_W-1:0]      max_col_nxt [PART_COUNT];
  logic [DIM_W-1:0]      min_row_nxt [PART_COUNT];
  logic [DIM_W-1:0]      max_row_nxt [PART_COUNT];

  logic [LABEL_W-1:0]    label_r;
  logic                  found_r;
  logic [DIM_W-1:0]      left_r, top_r;
  logic [SIZE_W-1:0]     width_r, height_r;
  logic                  last_r;

  logic [PAL_COUNT_W-1:0] used_cnt;
  logic [LABEL_W-1:0]     pix_label;
  logic [SIZE_W-1:0]      w_eff, h_eff, col_inc, row_inc;
  logic                   row_end, sprite_end;

  // config writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_chars_r  <= '0;
      pal_parts_r  <= '0;
      pal_count_r  <= '0;
      spr_width_r  <= SIZE_REG_W'(1);
      spr_height_r <= SIZE_REG_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_PAL_CHARS:  pal_chars_r  <= cfg_wdata[PAL_CHARS_W-1:0];
        REG_PAL_PARTS:  pal_parts_r  <= cfg_wdata[PAL_PARTS_W-1:0];
        REG_PAL_COUNT:  pal_count_r  <= cfg_wdata[PAL_COUNT_W-1:0];
        REG_SPR_WIDTH:  spr_width_r  <= cfg_wdata[SIZE_REG_W-1:0];
        REG_SPR_HEIGHT: spr_height_r <= cfg_wdata[SIZE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // palette lookup, scanned from the top entry down so the lowest match wins
  always_comb begin
    used_cnt = (32'(pal_count_r) > PALETTE_SIZE) ? PAL_COUNT_W'(PALETTE_SIZE) : pal_count_r;
    pix_label = '0;
    for (int k = PALETTE_SIZE - 1; k >= 0; k--) begin
      if ((k < 32'(used_cnt)) && (pal_chars_r[k*CODE_W +: CODE_W] == pixel_code)) begin
        pix_label = pal_parts_r[k*LABEL_W +: LABEL_W];
      end
    end
  end

  assign w_eff      = eff_dim(spr_width_r);
  assign h_eff      = eff_dim(spr_height_r);
  assign col_inc    = {1'b0, col_r} + SIZE_W'(1);
  assign row_inc    = {1'b0, row_r} + SIZE_W'(1);
  assign row_end    = (col_inc >= w_eff);
  assign sprite_end = row_end && (row_inc >= h_eff);
  assign status.sprite_end = sprite_end;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.accept) begin
      if (sprite_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_inc[DIM_W-1:0];
      end else begin
        col_nxt = col_inc[DIM_W-1:0];
      end
    end
  end

  // one lane per label, each comparing its own bounds against the pixel position
  always_comb begin
    seen_nxt = seen_r;
    for (int p = 0; p < PART_COUNT; p++) begin
      min_col_nxt[p] = min_col_r[p];
      max_col_nxt[p] = max_col_r[p];
      min_row_nxt[p] = min_row_r[p];
      max_row_nxt[p] = max_row_r[p];
      if (cmd.accept && (32'(pix_label) == p + 1)) begin
        seen_nxt[p] = 1'b1;
        if (!seen_r[p]) begin
          min_col_nxt[p] = col_r;
          max_col_nxt[p] = col_r;
          min_row_nxt[p] = row_r;
          max_row_nxt[p] = row_r;
        end else begin
          if (col_r < min_col_r[p]) min_col_nxt[p] = col_r;
          if (col_r > max_col_r[p]) max_col_nxt[p] = col_r;
          if (row_r < min_row_r[p]) min_row_nxt[p] = row_r;
          if (row_r > max_row_r[p]) max_row_nxt[p] = row_r;
        end
      end
    end
    if (cmd.clear_seen) begin
      seen_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      seen_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < PART_COUNT; p++) begin
      min_col_r[p] <= min_col_nxt[p];
      max_col_r[p] <= max_col_nxt[p];
      min_row_r[p] <= min_row_nxt[p];
      max_row_r[p] <= max_row_nxt[p];
    end
  end

  // result register, loaded one label per transfer slot
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      label_r <= LABEL_W'(cmd.idx) + LABEL_W'(1);
      last_r  <= (cmd.idx == IDX_W'(PART_COUNT - 1));
      if (seen_r[cmd.idx]) begin
        found_r  <= 1'b1;
        left_r   <= min_col_r[cmd.idx];
        top_r    <= min_row_r[cmd.idx];
        width_r  <= {1'b0, max_col_r[cmd.idx]} - {1'b0, min_col_r[cmd.idx]} + SIZE_W'(1);
        height_r <= {1'b0, max_row_r[cmd.idx]} - {1'b0, min_row_r[cmd.idx]} + SIZE_W'(1);
      end else begin
        found_r  <= 1'b0;
        left_r   <= '0;
        top_r    <= '0;
        width_r  <= '0;
        height_r <= '0;
      end
    end
  end

  assign part_label  = label_r;
  assign found       = found_r;
  assign box_left    = left_r;
  assign box_top     = top_r;
  assign box_width   = width_r;
  assign box_height  = height_r;
  assign last_of_run = last_r;

endmodule

FILE: rtl/core/sprite_part_bounding_boxes.sv
// Sprite part bounding boxes. Pixel codes stream in raster order, one per transfer, and each
// is mapped through the palette to a body-part label. Non-final pixels are taken one per
// clock with no gaps. The last pixel of a sprite starts the result sequence: seven results
// (labels 1..7, the last with tlast) leave the result register one per clock while out_tready
// is high, and in_tready stays low until the last of them has been loaded into the result
// register; the emit sequencer reads one label lane for each of those loads.
// Configuration must be written only while no transfer is in progress; the block itself does
// not enforce this. A size change in the middle of a sprite takes effect from the next pixel.
// top level; depends on spbb_pkg, spbb_ctrl and spbb_datapath
`timescale 1ns / 1ps

module sprite_part_bounding_boxes (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [spbb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [spbb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [spbb_pkg::CODE_W-1:0]     in_tdata,   // pixel_code
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [spbb_pkg::TDATA_W-1:0]    out_tdata,  // box_left, box_top, box_width, box_height
  output logic [spbb_pkg::TUSER_W-1:0]    out_tuser,  // part_label, found
  output logic                            out_tlast   // last_of_run
);
  import spbb_pkg::*;

  spbb_cmd_t          cmd;
  spbb_status_t       status;
  logic [LABEL_W-1:0] part_label;
  logic               found;
  logic [DIM_W-1:0]   box_left, box_top;
  logic [SIZE_W-1:0]  box_width, box_height;

  spbb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  spbb_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .pixel_code  (in_tdata),
    .cmd         (cmd),
    .status      (status),
    .part_label  (part_label),
    .found       (found),
    .box_left    (box_left),
    .box_top     (box_top),
    .box_width   (box_width),
    .box_height  (box_height),
    .last_of_run (out_tlast)
  );

  assign out_tdata = TDATA_W'({box_height, box_width, box_top, box_left});
  assign out_tuser = {found, part_label};

endmodule

FILE: rtl/core/spbb_checker.sv
// port-level checks for sprite_part_bounding_boxes, attached by the bind at the end
// depends on spbb_pkg
`timescale 1ns / 1ps

module spbb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [spbb_pkg::TDATA_W-1:0]    out_tdata,
  input logic [spbb_pkg::TUSER_W-1:0]    out_tuser,
  input logic                            out_tlast
);
  import spbb_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // the final result of a sprite reports the highest label
  a_last_label: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[LABEL_W-1:0] == LABEL_W'(PART_COUNT))
    else $error("tlast on wrong label");

  // an absent label reports an all-zero box
  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[LABEL_W] |-> out_tdata == '0)
    else $error("box fields nonzero for absent label");

  // no pixel is taken while a sprite's results are still being sent
  a_no_input_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |-> !in_tready)
    else $error("input taken during result sequence");

endmodule

bind sprite_part_bounding_boxes spbb_checker u_spbb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
